[design/dsq_pkg.sv]
// Shared types, codes and defaults of the deduplicating section work queue.
package dsq_pkg;

	// default sizes
	localparam int DSQ_QUEUE_DEPTH   = 128;
	localparam int DSQ_SLOT_COUNT    = 64;
	localparam int DSQ_SECTION_COUNT = 8;

	// fixed field widths
	localparam int SLOT_W    = 6;
	localparam int SECTION_W = 3;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int DEPTH_W   = 8;

	typedef enum logic [KIND_W-1:0] {
		K_ENQ   = 2'd0,
		K_FORCE = 2'd1,
		K_DROP  = 2'd2,
		K_POP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 3'd0,
		ST_ALREADY  = 3'd1,
		ST_FULL     = 3'd2,
		ST_PROMOTED = 3'd3,
		ST_EVICTED  = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_APPEND,
		FIN_PUSH,
		FIN_POP
	} fin_op_t;

	typedef struct packed {
		logic [SLOT_W-1:0]    slot;
		logic [SECTION_W-1:0] section;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request, arm scan counter
		logic rot;     // rotate chain by one entry
		logic finish;  // apply final edit, load result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;       // request needs no scan pass
		logic scan_zero;  // scan pass complete
	} dp_stat_t;

endpackage

[design/dsq_ctrl.sv]
// Controller state machine of the section work queue.
module dsq_ctrl import dsq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.skip || stat.scan_zero) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.rot = !(stat.skip || stat.scan_zero);
			end
			S_FINISH: begin
				cmd.finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/dsq_chain.sv]
// Datapath of the section work queue: entry cell chain, scan counter, result register.
module dsq_chain import dsq_pkg::*; #(
	parameter int QUEUE_DEPTH   = DSQ_QUEUE_DEPTH,
	parameter int SLOT_COUNT    = DSQ_SLOT_COUNT,
	parameter int SECTION_COUNT = DSQ_SECTION_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [KIND_W-1:0]    kind,
	input  logic [SLOT_W-1:0]    slot_index,
	input  logic [SECTION_W-1:0] section_index,
	output logic [STATUS_W-1:0]  status,
	output logic                 entry_valid,
	output logic [SLOT_W-1:0]    entry_slot,
	output logic [SECTION_W-1:0] entry_section,
	output logic [DEPTH_W-1:0]   queue_depth
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	kind_t                  kind_q;
	entry_t                 key_q;
	logic                   found_q;
	logic [CW-1:0]          scan_q;
	logic [CW-1:0]          count_q, count_fin;
	logic [QUEUE_DEPTH-1:0] occ_q, occ_d;
	entry_t                 cell_q [QUEUE_DEPTH];
	entry_t                 cell_d [QUEUE_DEPTH];

	entry_t  front, tail;
	logic    full, empty, in_range;
	logic    match_full, match_slot, discard;
	fin_op_t fin_op;
	status_t fin_status;
	logic    fin_ev;
	entry_t  fin_entry;
	logic [CW+DEPTH_W-1:0] depth_ext;

	assign front    = cell_q[0];
	assign tail     = cell_q[QUEUE_DEPTH-1];
	assign full     = occ_q[QUEUE_DEPTH-1];
	assign empty    = !occ_q[0];
	assign in_range = (int'(key_q.slot) < SLOT_COUNT) && (int'(key_q.section) < SECTION_COUNT);

	// head compare during the rotation pass
	assign match_full = (front == key_q);
	assign match_slot = (front.slot == key_q.slot);
	always_comb begin
		unique case (kind_q)
			K_DROP:  discard = match_slot;
			K_FORCE: discard = match_full;
			default: discard = 1'b0;
		endcase
	end

	assign stat.skip      = (kind_q == K_POP) || (!in_range && (kind_q == K_ENQ || kind_q == K_FORCE));
	assign stat.scan_zero = (scan_q == '0);

	// final edit and status
	always_comb begin
		fin_op     = FIN_NONE;
		fin_status = ST_DONE;
		fin_ev     = 1'b0;
		fin_entry  = '0;
		unique case (kind_q)
			K_ENQ: begin
				if (!in_range)   fin_status = ST_FULL;
				else if (found_q) fin_status = ST_ALREADY;
				else if (full)    fin_status = ST_FULL;
				else              fin_op     = FIN_APPEND;
			end
			K_FORCE: begin
				if (!in_range) begin
					fin_status = ST_FULL;
				end else if (found_q) begin
					fin_op     = FIN_PUSH;
					fin_status = ST_PROMOTED;
				end else if (full) begin
					fin_op     = FIN_PUSH;
					fin_status = ST_EVICTED;
					fin_ev     = 1'b1;
					fin_entry  = tail;
				end else begin
					fin_op = FIN_PUSH;
				end
			end
			K_DROP: ;
			K_POP: begin
				if (empty) begin
					fin_status = ST_EMPTY;
				end else begin
					fin_op    = FIN_POP;
					fin_ev    = 1'b1;
					fin_entry = front;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (fin_op)
			FIN_APPEND: count_fin = count_q + CW'(1);
			FIN_PUSH:   count_fin = full ? count_q : count_q + CW'(1);
			FIN_POP:    count_fin = count_q - CW'(1);
			default:    count_fin = count_q;
		endcase
	end

	// cell chain: each cell sees its neighbors, the head cell and the request key
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prv_cell, nxt_cell, c_d;
		logic   prv_occ, nxt_occ, o_d;

		if (i == 0) begin : g_first
			assign prv_cell = key_q;
			assign prv_occ  = 1'b1;
		end else begin : g_mid
			assign prv_cell = cell_q[i-1];
			assign prv_occ  = occ_q[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_cell = cell_q[i];
			assign nxt_occ  = 1'b0;
		end else begin : g_lo
			assign nxt_cell = cell_q[i+1];
			assign nxt_occ  = occ_q[i+1];
		end

		always_comb begin
			c_d = cell_q[i];
			o_d = occ_q[i];
			if (cmd.rot) begin
				// shift toward head; last occupied cell takes the old head back, freed if it is discarded
				if (nxt_occ) begin
					c_d = nxt_cell;
				end else if (occ_q[i]) begin
					c_d = front;
					o_d = !discard;
				end
			end else if (cmd.finish) begin
				unique case (fin_op)
					FIN_APPEND: begin
						if (!occ_q[i] && prv_occ) begin
							c_d = key_q;
							o_d = 1'b1;
						end
					end
					FIN_PUSH: begin
						c_d = prv_cell;
						o_d = prv_occ;
					end
					FIN_POP: begin
						c_d = nxt_cell;
						o_d = nxt_occ;
					end
					default: ;
				endcase
			end
		end

		assign cell_d[i] = c_d;
		assign occ_d[i]  = o_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (cmd.load) begin
				scan_q  <= count_q;
				found_q <= 1'b0;
			end else if (cmd.rot) begin
				scan_q  <= scan_q - CW'(1);
				found_q <= found_q | match_full;
				count_q <= count_q - CW'(discard);
			end else if (cmd.finish) begin
				count_q <= count_fin;
			end
		end
	end

	// payload registers
	assign depth_ext = {{DEPTH_W{1'b0}}, count_fin};

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) cell_q[i] <= cell_d[i];
		if (cmd.load) begin
			kind_q        <= kind_t'(kind);
			key_q.slot    <= slot_index;
			key_q.section <= section_index;
		end
		if (cmd.finish) begin
			status        <= fin_status;
			entry_valid   <= fin_ev;
			entry_slot    <= fin_entry.slot;
			entry_section <= fin_entry.section;
			queue_depth   <= depth_ext[DEPTH_W-1:0];
		end
	end

endmodule

[design/dedup_section_work_queue.sv]
// Top level of the deduplicating move-to-front section work queue.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_stall | kind, slot_index, section_index
//  out     | out_valid/out_stall | status, entry_valid, entry_slot, entry_section,
//          |                     | queue_depth
//
// Enqueue, force head and drop slot rotate the cell chain once through all queued
// entries, comparing one entry at the head per cycle.
// Pop and out-of-range enqueue or force-head requests skip the rotation pass.
// Reset clears the occupancy bits and the depth; no clearing pass is needed.
// A new request is taken while a result waits; the final edit waits until the
// earlier result has been taken.
module dedup_section_work_queue import dsq_pkg::*; #(
	parameter int QUEUE_DEPTH   = DSQ_QUEUE_DEPTH,
	parameter int SLOT_COUNT    = DSQ_SLOT_COUNT,
	parameter int SECTION_COUNT = DSQ_SECTION_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [SLOT_W-1:0]    slot_index,
	input  logic [SECTION_W-1:0] section_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic                 entry_valid,
	output logic [SLOT_W-1:0]    entry_slot,
	output logic [SECTION_W-1:0] entry_section,
	output logic [DEPTH_W-1:0]   queue_depth
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dsq_chain #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.SLOT_COUNT    (SLOT_COUNT),
		.SECTION_COUNT (SECTION_COUNT)
	) u_chain (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.slot_index    (slot_index),
		.section_index (section_index),
		.status        (status),
		.entry_valid   (entry_valid),
		.entry_slot    (entry_slot),
		.entry_section (entry_section),
		.queue_depth   (queue_depth)
	);

endmodule

[design/dsq_checker.sv]
// Port-level checker of the section work queue and its bind.
module dsq_checker import dsq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                entry_valid,
	input logic [DEPTH_W-1:0]  queue_depth
);

	// one request at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(queue_depth))
		else $error("stalled result changed");

	// an entry is reported only by a pop or an eviction
	a_entry_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> (status == ST_DONE || status == ST_EVICTED))
		else $error("entry reported with wrong status");

	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> queue_depth == '0 && !entry_valid)
		else $error("empty status with entries");

endmodule

bind dedup_section_work_queue dsq_checker u_dsq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.entry_valid (entry_valid),
	.queue_depth (queue_depth)
);

[sim/tb.sv]
// Self-checking testbench of the deduplicating section work queue.
module tb;
	import dsq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = DSQ_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		status_t        status;
		logic           entry_valid;
		logic [SLOT_W-1:0]    entry_slot;
		logic [SECTION_W-1:0] entry_section;
		logic [DEPTH_W-1:0]   queue_depth;
	} queue_result_t;

	// queue model and pending expected results
	class queue_scoreboard;
		entry_t        order[$];
		bit            member[DSQ_SLOT_COUNT*DSQ_SECTION_COUNT];
		queue_result_t pending[$];
		int            mismatches;
		int            checked;
		int            evictions;
		int            promotions;

		function int find_entry(logic [SLOT_W-1:0] s, logic [SECTION_W-1:0] c);
			int pos;
			pos = -1;
			if (member[s*DSQ_SECTION_COUNT+c]) begin
				foreach (order[i]) begin
					if (order[i].slot == s && order[i].section == c && pos < 0) pos = i;
				end
			end
			return pos;
		endfunction

		// apply one accepted request and queue its expected result
		function void note_request(kind_t k, logic [SLOT_W-1:0] s, logic [SECTION_W-1:0] c);
			queue_result_t r;
			entry_t e;
			int pos;
			bit in_range;
			r.status = ST_DONE;
			r.entry_valid = 0;
			r.entry_slot = 0;
			r.entry_section = 0;
			e.slot = s;
			e.section = c;
			in_range = (s < DSQ_SLOT_COUNT) && (c < DSQ_SECTION_COUNT);
			case (k)
				K_ENQ: begin
					if (!in_range) r.status = ST_FULL;
					else if (member[s*DSQ_SECTION_COUNT+c]) r.status = ST_ALREADY;
					else if (order.size() >= QDEPTH) r.status = ST_FULL;
					else begin
						order.insert(order.size(), e);
						member[s*DSQ_SECTION_COUNT+c] = 1;
					end
				end
				K_FORCE: begin
					if (!in_range) r.status = ST_FULL;
					else begin
						pos = find_entry(s, c);
						if (pos >= 0) begin
							order.delete(pos);
							r.status = ST_PROMOTED;
							promotions++;
						end else if (order.size() >= QDEPTH) begin
							r.entry_valid = 1;
							r.entry_slot = order[$].slot;
							r.entry_section = order[$].section;
							member[order[$].slot*DSQ_SECTION_COUNT+order[$].section] = 0;
							void'(order.pop_back());
							r.status = ST_EVICTED;
							evictions++;
						end
						order.push_front(e);
						member[s*DSQ_SECTION_COUNT+c] = 1;
					end
				end
				K_DROP: begin
					for (int i = order.size() - 1; i >= 0; i--) begin
						if (order[i].slot == s) begin
							member[order[i].slot*DSQ_SECTION_COUNT+order[i].section] = 0;
							order.delete(i);
						end
					end
				end
				default: begin
					if (order.size() == 0) r.status = ST_EMPTY;
					else begin
						r.entry_valid = 1;
						r.entry_slot = order[0].slot;
						r.entry_section = order[0].section;
						member[order[0].slot*DSQ_SECTION_COUNT+order[0].section] = 0;
						void'(order.pop_front());
					end
				end
			endcase
			r.queue_depth = DEPTH_W'(order.size());
			pending.insert(pending.size(), r);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(queue_result_t got);
			queue_result_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.entry_valid !== want.entry_valid ||
			    got.entry_slot !== want.entry_slot ||
			    got.entry_section !== want.entry_section ||
			    got.queue_depth !== want.queue_depth) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: exp st=%0d v=%0d %0d/%0d d=%0d got st=%0d v=%0d %0d/%0d d=%0d",
						checked, want.status, want.entry_valid, want.entry_slot,
						want.entry_section, want.queue_depth, got.status, got.entry_valid,
						got.entry_slot, got.entry_section, got.queue_depth);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [KIND_W-1:0]    kind;
	logic [SLOT_W-1:0]    slot_index;
	logic [SECTION_W-1:0] section_index;
	logic [STATUS_W-1:0]  status;
	logic entry_valid;
	logic [SLOT_W-1:0]    entry_slot;
	logic [SECTION_W-1:0] entry_section;
	logic [DEPTH_W-1:0]   queue_depth;

	queue_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int hold_cycles;
	int cycles;

	dedup_section_work_queue u_dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// receiver: random stall, or a long hold-off when requested
	initial begin
		queue_result_t got;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.status = status_t'(status);
				got.entry_valid = entry_valid;
				got.entry_slot = entry_slot;
				got.entry_section = entry_section;
				got.queue_depth = queue_depth;
				sb.check_result(got);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("dedup_section_work_queue regression: fail");
				$finish;
			end
		end
	end

	// offer one request, holding it until accepted
	task automatic send_request(kind_t k, int s, int c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		slot_index <= SLOT_W'(s);
		section_index <= SECTION_W'(c);
		do @(posedge clk); while (in_stall);
		sb.note_request(k, SLOT_W'(s), SECTION_W'(c));
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (QDEPTH + 10) @(posedge clk);
	endtask

	// in-range workload, mostly on a small slot set so hits and fills happen
	task automatic random_requests(int n, int slot_span);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40) send_request(K_ENQ, $urandom_range(slot_span), $urandom_range(7));
			else if (r < 65) send_request(K_FORCE, $urandom_range(slot_span), $urandom_range(7));
			else if (r < 75) send_request(K_DROP, $urandom_range(slot_span), $urandom_range(7));
			else send_request(K_POP, $urandom_range(63), $urandom_range(7));
		end
	endtask

	initial begin
		sb = new();
		in_valid = 0;
		kind = K_ENQ;
		slot_index = 0;
		section_index = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty pop, field extremes, duplicates, promotion, drop
		send_request(K_POP, 0, 0);
		send_request(K_ENQ, 0, 0);
		send_request(K_ENQ, 63, 7);
		send_request(K_ENQ, 63, 7);
		send_request(K_FORCE, 63, 7);
		send_request(K_FORCE, 21, 5);
		send_request(K_ENQ, 21, 2);
		send_request(K_DROP, 21, 0);
		send_request(K_DROP, 42, 7);
		send_request(K_POP, 63, 7);
		send_request(K_POP, 0, 0);
		send_request(K_POP, 0, 0);
		// fill to full, then full and duplicate enqueue, force-head eviction and promotion, drop
		for (int i = 0; i < QDEPTH; i++) send_request(K_ENQ, i / 8, i % 8);
		send_request(K_ENQ, 40, 1);
		send_request(K_ENQ, 3, 3);
		send_request(K_FORCE, 40, 1);
		send_request(K_FORCE, 41, 6);
		send_request(K_FORCE, 2, 0);
		send_request(K_DROP, 1, 0);
		wait_drained();

		// random phases across idling mixes
		send_idle_pct = 0;  recv_stall_pct = 0;  random_requests(100, 20);
		send_idle_pct = 75; recv_stall_pct = 0;  random_requests(70, 20);
		send_idle_pct = 0;  recv_stall_pct = 75; random_requests(70, 63);
		wait_drained();
		// long receiver hold-off while the sender keeps pushing
		send_idle_pct = 0;  recv_stall_pct = 0;
		hold_cycles = 400;
		random_requests(40, 10);
		wait_drained();
		send_idle_pct = 37; recv_stall_pct = 37; random_requests(100, 16);
		// full-queue stress for evictions
		send_idle_pct = 0;  recv_stall_pct = 0;
		for (int i = 0; i < 110; i++) send_request(K_ENQ, $urandom_range(63), $urandom_range(7));
		random_requests(20, 63);
		wait_drained();

		$display("covered %0d results, %0d evictions, %0d promotions under four idling mixes",
			sb.checked, sb.evictions, sb.promotions);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("dedup_section_work_queue regression: pass");
		else
			$display("dedup_section_work_queue regression: fail");
		$finish;
	end
endmodule

[files.f]
design/dsq_pkg.sv
design/dsq_ctrl.sv
design/dsq_chain.sv
design/dedup_section_work_queue.sv
design/dsq_checker.sv
sim/tb.sv
